// ===== sv/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// types and codes shared by the indexed list engine
// ----------------------------------------------------------------------------
package ile_pkg;

  // item field widths below are sized for these values
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam logic [3:0] ACT_GET_AT       = 4'd0;
  localparam logic [3:0] ACT_GET_FIRST    = 4'd1;
  localparam logic [3:0] ACT_GET_LAST     = 4'd2;
  localparam logic [3:0] ACT_POP_AT       = 4'd3;
  localparam logic [3:0] ACT_POP_FIRST    = 4'd4;
  localparam logic [3:0] ACT_POP_LAST     = 4'd5;
  localparam logic [3:0] ACT_INSERT_AT    = 4'd6;
  localparam logic [3:0] ACT_INSERT_FIRST = 4'd7;
  localparam logic [3:0] ACT_INSERT_LAST  = 4'd8;
  localparam logic [3:0] ACT_CLEAR        = 4'd9;
  localparam logic [3:0] ACT_STATUS       = 4'd10;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [3:0]  action;
    logic [5:0]  position;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_data;
    logic [1:0]  status;
    logic [6:0]  element_count;
    logic        is_empty;
  } out_item_t;

endpackage

// ===== sv/ile_ram.sv =====
// ----------------------------------------------------------------------------
// ile_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine
// bounded ordered list of linked nodes with a free list
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result item. Links and payloads
// sit in two rams with a registered read; a sequencer walks the link ram one
// node per cycle. Status, clear and any failing request go straight to the
// result; get_last reads its tail node directly, pops at index zero and
// front and back inserts need no walk, and the other gets, pops and
// mid-list inserts walk from the head towards the element index, so the
// walk sets how long a request runs. A stalled result holds the engine in
// its last step until the previous result leaves. Unused nodes are handed
// out from a fill mark, so no clearing pass follows reset or clear.
`include "assert_macros.svh"

module indexed_list_engine import ile_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (LW > 6) ? LW : 6;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_WALK     = 5'd1;
  localparam logic [4:0] S_GET_RD   = 5'd2;
  localparam logic [4:0] S_GET_DONE = 5'd3;
  localparam logic [4:0] S_POP0_RD  = 5'd4;
  localparam logic [4:0] S_POP0_WB  = 5'd5;
  localparam logic [4:0] S_POPK_A   = 5'd6;
  localparam logic [4:0] S_POPK_B   = 5'd7;
  localparam logic [4:0] S_POPK_C   = 5'd8;
  localparam logic [4:0] S_REL      = 5'd9;
  localparam logic [4:0] S_ALLOC    = 5'd10;
  localparam logic [4:0] S_ALLOC_W  = 5'd11;
  localparam logic [4:0] S_INS_B1   = 5'd12;
  localparam logic [4:0] S_INS_B2   = 5'd13;
  localparam logic [4:0] S_INS_F    = 5'd14;
  localparam logic [4:0] S_INS_KA   = 5'd15;
  localparam logic [4:0] S_INS_KB   = 5'd16;
  localparam logic [4:0] S_INS_KC   = 5'd17;
  localparam logic [4:0] S_EMIT     = 5'd18;

  localparam logic [1:0] M_BACK  = 2'd0;
  localparam logic [1:0] M_FRONT = 2'd1;
  localparam logic [1:0] M_MID   = 2'd2;

  logic [4:0]            state_r, state_nxt, after_r, after_nxt;
  logic [LW-1:0]         first_r, first_nxt, last_r, last_nxt;
  logic [LW-1:0]         free_r, free_nxt, hwm_r, hwm_nxt, count_r, count_nxt;
  logic [LW-1:0]         cur_r, cur_nxt, n_r, n_nxt;
  logic [XW-1:0]         steps_r, steps_nxt;
  logic                  wfirst_r, wfirst_nxt, from_free_r, from_free_nxt;
  logic [1:0]            mode_r, mode_nxt, status_r, status_nxt;
  logic [DATA_WIDTH-1:0] pay_r, pay_nxt, data_r, data_nxt;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  l_we, l_re, p_we, p_re;
  logic [AW-1:0]         l_waddr, l_raddr, p_waddr, p_raddr;
  logic [LW-1:0]         l_wdata, l_rdata;
  logic [DATA_WIDTH-1:0] p_rdata;

  logic [XW-1:0]         px, cx, k;
  logic [LW-1:0]         cur_c;
  logic [63:0]           pay64;
  logic [12:0]           cnt13;

  ile_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  ile_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_payload (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(pay_r),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign px    = XW'(in_item.position);
  assign cx    = XW'(count_r);
  assign pay64 = 64'(in_item.payload);
  assign cnt13 = 13'(count_r);
  // walk follows the link just read, except on its first step
  assign cur_c = wfirst_r ? cur_r : l_rdata;

  always_comb begin
    state_nxt = state_r;   after_nxt = after_r;
    first_nxt = first_r;   last_nxt = last_r;
    free_nxt = free_r;     hwm_nxt = hwm_r;     count_nxt = count_r;
    cur_nxt = cur_r;       n_nxt = n_r;         steps_nxt = steps_r;
    wfirst_nxt = wfirst_r; from_free_nxt = from_free_r;
    mode_nxt = mode_r;     status_nxt = status_r;
    pay_nxt = pay_r;       data_nxt = data_r;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_re = 1'b0; p_raddr = '0;
    k = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt   = '0;
          status_nxt = ST_OK;
          pay_nxt    = pay64[DATA_WIDTH-1:0];
          cur_nxt    = first_r;
          wfirst_nxt = 1'b1;
          state_nxt  = S_EMIT;
          case (in_item.action)
            ACT_GET_AT, ACT_GET_FIRST, ACT_GET_LAST: begin
              k = (in_item.action == ACT_GET_FIRST) ? '0 :
                  (in_item.action == ACT_GET_LAST) ? cx - 1'b1 : px;
              if (count_r == '0 || k >= cx) begin
                status_nxt = ST_MISSING;
              end else if (in_item.action == ACT_GET_LAST) begin
                cur_nxt   = last_r;
                state_nxt = S_GET_RD;
              end else begin
                steps_nxt = k;
                after_nxt = S_GET_RD;
                state_nxt = S_WALK;
              end
            end
            ACT_POP_AT, ACT_POP_FIRST, ACT_POP_LAST: begin
              k = (in_item.action == ACT_POP_FIRST) ? '0 :
                  (in_item.action == ACT_POP_LAST) ? cx - 1'b1 : px;
              if (count_r == '0 || k >= cx) begin
                status_nxt = ST_MISSING;
              end else if (k == '0) begin
                n_nxt     = first_r;
                state_nxt = S_POP0_RD;
              end else begin
                steps_nxt = k - 1'b1;
                after_nxt = S_POPK_A;
                state_nxt = S_WALK;
              end
            end
            ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_INSERT_LAST: begin
              if (count_r >= NIL) begin
                status_nxt = ST_FULL;
              end else if (in_item.action == ACT_INSERT_AT && px != '0 && px >= cx) begin
                status_nxt = ST_MISSING;
              end else begin
                if (in_item.action == ACT_INSERT_LAST) begin
                  mode_nxt = M_BACK;
                end else if (in_item.action == ACT_INSERT_FIRST || px == '0) begin
                  mode_nxt = M_FRONT;
                end else begin
                  mode_nxt = M_MID;
                end
                steps_nxt = px - 1'b1;
                state_nxt = S_ALLOC;
              end
            end
            ACT_CLEAR: begin
              first_nxt = NIL;
              last_nxt  = NIL;
              free_nxt  = NIL;
              hwm_nxt   = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (steps_r == '0) begin
          cur_nxt   = cur_c;
          state_nxt = after_r;
        end else begin
          l_re       = 1'b1;
          l_raddr    = cur_c[AW-1:0];
          steps_nxt  = steps_r - 1'b1;
          wfirst_nxt = 1'b0;
        end
      end
      S_GET_RD: begin
        p_re      = 1'b1;
        p_raddr   = cur_r[AW-1:0];
        state_nxt = S_GET_DONE;
      end
      S_GET_DONE: begin
        data_nxt  = p_rdata;
        state_nxt = S_EMIT;
      end
      S_POP0_RD: begin
        l_re      = 1'b1;
        l_raddr   = n_r[AW-1:0];
        p_re      = 1'b1;
        p_raddr   = n_r[AW-1:0];
        state_nxt = S_POP0_WB;
      end
      S_POP0_WB: begin
        first_nxt = l_rdata;
        if (l_rdata == NIL) begin
          last_nxt = NIL;
        end
        data_nxt  = p_rdata;
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = free_r;
        free_nxt  = n_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_EMIT;
      end
      S_POPK_A: begin
        l_re      = 1'b1;
        l_raddr   = cur_r[AW-1:0];
        state_nxt = S_POPK_B;
      end
      S_POPK_B: begin
        n_nxt     = l_rdata;
        l_re      = 1'b1;
        l_raddr   = l_rdata[AW-1:0];
        p_re      = 1'b1;
        p_raddr   = l_rdata[AW-1:0];
        state_nxt = S_POPK_C;
      end
      S_POPK_C: begin
        // unlink the removed node from its predecessor
        l_we     = 1'b1;
        l_waddr  = cur_r[AW-1:0];
        l_wdata  = l_rdata;
        data_nxt = p_rdata;
        if (n_r == last_r) begin
          last_nxt = cur_r;
        end
        state_nxt = S_REL;
      end
      S_REL: begin
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = free_r;
        free_nxt  = n_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_EMIT;
      end
      S_ALLOC: begin
        // reuse a released node first, else take a fresh one at the fill mark
        if (free_r != NIL) begin
          l_re          = 1'b1;
          l_raddr       = free_r[AW-1:0];
          n_nxt         = free_r;
          from_free_nxt = 1'b1;
        end else begin
          n_nxt         = hwm_r;
          hwm_nxt       = hwm_r + 1'b1;
          from_free_nxt = 1'b0;
        end
        state_nxt = S_ALLOC_W;
      end
      S_ALLOC_W: begin
        if (from_free_r) begin
          free_nxt = l_rdata;
        end
        p_we    = 1'b1;
        p_waddr = n_r[AW-1:0];
        case (mode_r)
          M_BACK:  state_nxt = S_INS_B1;
          M_FRONT: state_nxt = S_INS_F;
          default: begin
            cur_nxt    = first_r;
            wfirst_nxt = 1'b1;
            after_nxt  = S_INS_KA;
            state_nxt  = S_WALK;
          end
        endcase
      end
      S_INS_B1: begin
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = NIL;
        state_nxt = S_INS_B2;
      end
      S_INS_B2: begin
        if (last_r != NIL) begin
          l_we    = 1'b1;
          l_waddr = last_r[AW-1:0];
          l_wdata = n_r;
        end else begin
          first_nxt = n_r;
        end
        last_nxt  = n_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_EMIT;
      end
      S_INS_F: begin
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = first_r;
        first_nxt = n_r;
        if (last_r == NIL) begin
          last_nxt = n_r;
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_EMIT;
      end
      S_INS_KA: begin
        l_re      = 1'b1;
        l_raddr   = cur_r[AW-1:0];
        state_nxt = S_INS_KB;
      end
      S_INS_KB: begin
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = l_rdata;
        state_nxt = S_INS_KC;
      end
      S_INS_KC: begin
        l_we    = 1'b1;
        l_waddr = cur_r[AW-1:0];
        l_wdata = n_r;
        if (cur_r == last_r) begin
          last_nxt = n_r;
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= NIL;
      last_r      <= NIL;
      free_r      <= NIL;
      hwm_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      free_r  <= free_nxt;
      hwm_r   <= hwm_nxt;
      count_r <= count_nxt;
      if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    after_r     <= after_nxt;
    cur_r       <= cur_nxt;
    n_r         <= n_nxt;
    steps_r     <= steps_nxt;
    wfirst_r    <= wfirst_nxt;
    from_free_r <= from_free_nxt;
    mode_r      <= mode_nxt;
    status_r    <= status_nxt;
    pay_r       <= pay_nxt;
    data_r      <= data_nxt;
    if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_r.result_data   <= 32'(64'(data_r));
      out_r.status        <= status_r;
      out_r.element_count <= cnt13[6:0];
      out_r.is_empty      <= (count_r == '0);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= NIL, "element count above capacity")
  `ASSERT_ALWAYS(a_hwm_bound, clk, rst_n, hwm_r <= NIL, "fill mark above capacity")
  `ASSERT_IMPLY(a_empty_links, clk, rst_n, state_r == S_IDLE, (count_r == '0) == (first_r == NIL) && (count_r == '0) == (last_r == NIL), "head or tail disagrees with count")
  `ASSERT_IMPLY(a_walk_live, clk, rst_n, state_r == S_WALK && !wfirst_r, l_rdata != NIL || steps_r == '0, "walk ran off the list end")

endmodule

// ===== test/indexed_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// drives random and directed list requests and checks every result against
// an array-based model of the ordered list
// ----------------------------------------------------------------------------
module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 2000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  indexed_list_engine DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  // model of the list: element 0 is the front
  logic [31:0] list_q[$];
  out_item_t   pending_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          rx_random = 1'b1;

  function automatic out_item_t list_apply(in_item_t it);
    out_item_t r;
    int unsigned cnt;
    int unsigned pos;
    logic [3:0] act;
    cnt = list_q.size();
    pos = it.position;
    act = it.action;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_GET_AT, ACT_GET_FIRST, ACT_GET_LAST,
      ACT_POP_AT, ACT_POP_FIRST, ACT_POP_LAST: begin
        if (act == ACT_GET_FIRST || act == ACT_POP_FIRST) pos = 0;
        if (act == ACT_GET_LAST || act == ACT_POP_LAST) pos = cnt - 1;
        if (cnt == 0 || pos >= cnt) begin
          r.status = ST_MISSING;
        end else begin
          r.result_data = list_q[pos];
          if (act == ACT_POP_AT || act == ACT_POP_FIRST || act == ACT_POP_LAST)
            list_q.delete(pos);
        end
      end
      ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_INSERT_LAST: begin
        if (cnt >= CAP) r.status = ST_FULL;
        else if (act == ACT_INSERT_AT && pos != 0 && pos >= cnt) r.status = ST_MISSING;
        else if (act == ACT_INSERT_LAST) list_q.push_back(it.payload);
        else if (act == ACT_INSERT_FIRST) list_q.push_front(it.payload);
        else list_q.insert(pos, it.payload);
      end
      ACT_CLEAR: list_q.delete();
      default: ;
    endcase
    r.element_count = 7'(list_q.size());
    r.is_empty = (list_q.size() == 0);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // valid stays up from one item to the next when there is no gap
  task automatic send_item(logic [3:0] act, logic [5:0] pos, logic [31:0] pay,
                           bit gaps = 1'b1);
    int gap;
    in_item_t it;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.action = act;
    it.position = pos;
    it.payload = pay;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(list_apply(it));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // receiver stall, random or held while hold_off counts down
  initial begin
    int wait_n;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (rx_random) begin
        wait_n = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n - 1) @(negedge clk);
          @(negedge clk);
        end
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("** indexed_list_engine: FAILED **");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report("unexpected item", out_item.result_data, 32'h0);
      end else begin
        want = pending_q.pop_front();
        if (out_item.result_data !== want.result_data)
          report("result_data", out_item.result_data, want.result_data);
        if (out_item.status !== want.status)
          report("status", 32'(out_item.status), 32'(want.status));
        if (out_item.element_count !== want.element_count)
          report("element_count", 32'(out_item.element_count),
                 32'(want.element_count));
        if (out_item.is_empty !== want.is_empty)
          report("is_empty", 32'(out_item.is_empty), 32'(want.is_empty));
      end
    end
  end

  task automatic test_directed();
    send_item(ACT_STATUS, 6'd0, 32'h0);
    send_item(ACT_GET_FIRST, 6'd0, 32'h0);
    send_item(ACT_GET_LAST, 6'd0, 32'h0);
    send_item(ACT_POP_FIRST, 6'd0, 32'h0);
    send_item(ACT_POP_LAST, 6'd0, 32'h0);
    send_item(ACT_GET_AT, 6'd63, 32'h0);
    send_item(ACT_POP_AT, 6'd0, 32'h0);
    send_item(ACT_INSERT_AT, 6'd5, 32'h1);          // before a missing element
    send_item(ACT_INSERT_AT, 6'd0, 32'hffffffff);   // index zero on empty list
    send_item(ACT_INSERT_FIRST, 6'd0, 32'h0);
    send_item(ACT_INSERT_LAST, 6'd0, 32'ha5a5a5a5);
    send_item(ACT_INSERT_AT, 6'd2, 32'h5a5a5a5a);
    send_item(ACT_INSERT_AT, 6'd1, 32'h12345678);
    send_item(ACT_GET_AT, 6'd1, 32'h0);
    send_item(ACT_GET_AT, 6'd4, 32'h0);
    send_item(ACT_GET_LAST, 6'd0, 32'h0);
    send_item(ACT_POP_AT, 6'd2, 32'h0);
    send_item(ACT_POP_LAST, 6'd0, 32'h0);
    send_item(ACT_POP_FIRST, 6'd0, 32'h0);
    send_item(4'd11, 6'd3, 32'h0);
    send_item(4'd15, 6'd63, 32'hffffffff);
    send_item(ACT_CLEAR, 6'd0, 32'h0);
    send_item(ACT_GET_FIRST, 6'd0, 32'h0);
  endtask

  task automatic test_full_list();
    send_item(ACT_CLEAR, 6'd0, 32'h0);
    repeat (CAP) send_item(ACT_INSERT_LAST, 6'($urandom), $urandom, 1'b0);
    send_item(ACT_INSERT_FIRST, 6'd0, 32'h1);
    send_item(ACT_INSERT_AT, 6'd63, 32'h2);
    send_item(ACT_INSERT_LAST, 6'd0, 32'h3);
    send_item(ACT_GET_AT, 6'd63, 32'h0);
    send_item(ACT_POP_LAST, 6'd0, 32'h0);
    send_item(ACT_POP_AT, 6'd62, 32'h0);
    send_item(ACT_INSERT_AT, 6'd62, 32'h4);
    wait_drained();  // sender pauses until all results are in
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (10) send_item(ACT_GET_AT, 6'($urandom_range(0, 63)), 32'h0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int n_items);
    int k;
    int unsigned cnt;
    logic [3:0] act;
    logic [5:0] pos;
    for (k = 0; k < n_items; k++) begin
      cnt = list_q.size();
      act = 4'($urandom_range(0, 10));
      // lean on inserts while short, pops while long, rare clears
      if (act == ACT_CLEAR && $urandom_range(0, 7) != 0) act = ACT_INSERT_AT;
      if (cnt < 20 && $urandom_range(0, 2) == 0) act = ACT_INSERT_AT;
      if (cnt > 56 && $urandom_range(0, 2) == 0) act = ACT_POP_AT;
      if ($urandom_range(0, 40) == 0) act = 4'($urandom_range(11, 15));
      if (cnt != 0 && $urandom_range(0, 5) != 0) pos = 6'($urandom_range(0, cnt - 1));
      else pos = 6'($urandom);
      send_item(act, pos, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(700);
    rx_random = 1'b0;
    test_random(300);
    rx_random = 1'b1;
    test_random(300);
    wait_drained();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** indexed_list_engine: PASSED **");
    end else begin
      $display("** indexed_list_engine: FAILED **");
    end
    $finish;
  end
endmodule
